// ----- rtl/bda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  // Width of the binary value that is converted; bits above it are ignored.
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned InWidth     = 64;
  // Decimal digits that cover the largest ValueWidth-bit value: ceil(W * log10(2)).
  localparam int unsigned NumDigits   = (ValueWidth * 30103) / 100000 + 1;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned BcdWidth    = DigitWidth * NumDigits;
  localparam int unsigned CharWidth   = 6;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  localparam logic [CharWidth-1:0]  AsciiZero = CharWidth'(48);
  localparam logic [DigitWidth-1:0] DabbleMin = DigitWidth'(5);
  localparam logic [DigitWidth-1:0] DabbleAdd = DigitWidth'(3);

  typedef logic [BcdWidth-1:0]   bcd_t;
  typedef logic [ValueWidth-1:0] bin_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } bda_state_e;

endpackage

`default_nettype wire

// ----- rtl/bda_value_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bda_value_if import bda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [InWidth-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/bda_digit_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bda_digit_if import bda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                        Beat
// value_i   in   value[63:0]                   one binary value to convert
// digit_o   out  digit_char[5:0], last_digit   one ASCII digit, MSD first
//
// A value is converted in two phases: each binary bit in turn passes
// through the shared shift-add-3 unit, then each BCD digit position is
// walked in turn. Reset is asynchronous and active low and clears
// the sequencer and the output valid. A stalled output holds the digit
// walk; the input is ready again as soon as the last digit is registered.
module binary_to_decimal_ascii import bda_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bda_value_if.sink    value_i,
  bda_digit_if.source  digit_o
);

  bda_state_e state_q, state_d;
  bin_t       bin_q, bin_d;
  bcd_t       bcd_q, bcd_d;
  bcd_t       bcd_step;
  logic [BitCntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntWidth-1:0] dig_cnt_q, dig_cnt_d;
  logic       started_q, started_d;

  logic                  out_valid_q, out_valid_d;
  logic [CharWidth-1:0]  out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [DigitWidth-1:0] top_digit;
  logic                  is_last;
  logic                  out_free;
  logic                  skip;
  logic                  push;

  // The shared arithmetic unit: one double-dabble step per cycle.
  bda_dabble_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[ValueWidth-1]),
    .bcd_o (bcd_step)
  );

  assign value_i.ready = (state_q == StIdle);

  // During the digit walk the most significant BCD digit is looked at, and
  // leading zeros are dropped until the first nonzero digit or the last one.
  assign top_digit = bcd_q[BcdWidth-1 -: DigitWidth];
  assign is_last   = (dig_cnt_q == '0);
  assign out_free  = !out_valid_q || digit_o.ready;
  assign skip      = (top_digit == '0) && !started_q && !is_last;
  assign push      = (state_q == StEmit) && !skip && out_free;

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    started_d = started_q;

    case (state_q)
      StIdle: begin
        if (value_i.valid) begin
          bin_d     = value_i.value[ValueWidth-1:0];
          bcd_d     = '0;
          bit_cnt_d = BitCntWidth'(ValueWidth - 1);
          started_d = 1'b0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        bin_d = {bin_q[ValueWidth-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DigCntWidth'(NumDigits - 1);
          state_d   = StEmit;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      StEmit: begin
        if (skip || push) begin
          bcd_d     = {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
          started_d = started_q | push;
          if (is_last) begin
            state_d = StIdle;
          end else begin
            dig_cnt_d = dig_cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: parts the digit walk from the consumer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_char_d  = AsciiZero + CharWidth'(top_digit);
      out_last_d  = is_last;
    end else if (digit_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    bit_cnt_q  <= bit_cnt_d;
    dig_cnt_q  <= dig_cnt_d;
    started_q  <= started_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign digit_o.valid      = out_valid_q;
  assign digit_o.digit_char = out_char_q;
  assign digit_o.last_digit = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/bda_dabble_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One shift-and-add-3 step: every BCD digit of five or more gets three added,
// then the whole register shifts left by one and takes in the next binary bit.
module bda_dabble_step import bda_pkg::*; (
  input  wire bcd_t bcd_i,
  input  wire logic bit_i,
  output bcd_t      bcd_o
);

  bcd_t adj;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_i[i*DigitWidth +: DigitWidth] >= DabbleMin) begin
        adj[i*DigitWidth +: DigitWidth] = bcd_i[i*DigitWidth +: DigitWidth] + DabbleAdd;
      end else begin
        adj[i*DigitWidth +: DigitWidth] = bcd_i[i*DigitWidth +: DigitWidth];
      end
    end
  end

  assign bcd_o = {adj[BcdWidth-2:0], bit_i};

endmodule

`default_nettype wire

// ----- tb/bda_digit_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts the digit run of every accepted value and
// compares each accepted digit beat against the oldest outstanding digit.
module bda_digit_checker import bda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bda_value_if        value_mon,
  bda_digit_if        digit_mon,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  typedef struct packed {
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  digit_beat_t digits_due[$];
  int unsigned mismatch_count;

  assign mismatches_o = mismatch_count;

  // Queues the decimal text of one value, most significant digit first.
  function automatic void queue_decimal_text(input logic [InWidth-1:0] raw);
    logic [63:0] rest;
    logic [3:0]  lsd_first [NumDigits];
    int          n;
    digit_beat_t beat;
    rest = 64'(bin_t'(raw));
    n    = 0;
    do begin
      lsd_first[n] = 4'(rest % 64'd10);
      rest         = rest / 64'd10;
      n++;
    end while (rest != 0 && n < NumDigits);
    for (int k = n - 1; k >= 0; k--) begin
      beat.digit_char = AsciiZero + CharWidth'(lsd_first[k]);
      beat.last_digit = (k == 0);
      digits_due.push_back(beat);
    end
  endfunction

  initial begin
    mismatch_count = 0;
    pending_o      = 0;
  end

  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_ni) begin
      if (value_mon.valid && value_mon.ready) begin
        queue_decimal_text(value_mon.value);
      end
      if (digit_mon.valid && digit_mon.ready) begin
        if (digits_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected digit beat: expected none, actual char %0d last %0b",
                   $time, digit_mon.digit_char, digit_mon.last_digit);
        end else begin
          want = digits_due.pop_front();
          if (digit_mon.digit_char !== want.digit_char) begin
            mismatch_count++;
            $display("%0t: digit_char: expected %0d, actual %0d",
                     $time, want.digit_char, digit_mon.digit_char);
          end
          if (digit_mon.last_digit !== want.last_digit) begin
            mismatch_count++;
            $display("%0t: last_digit: expected %0b, actual %0b",
                     $time, want.last_digit, digit_mon.last_digit);
          end
        end
      end
      pending_o <= digits_due.size();
    end
  end

endmodule

// ----- tb/binary_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps

// Top of the converter bench. It generates the clock and reset, offers
// values on the input channel, throttles the digit channel, and gives the
// verdict. All prediction and comparison lives in the checker instance.
module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  // Number of values offered in total, directed part included.
  localparam int unsigned TotalValues = 460;
  // The final stretch of values is sent with both sides running flat out.
  localparam int unsigned TailValues  = 60;
  // Values sent before the digit sink goes quiet for one long stretch.
  localparam int unsigned HoldOffAt   = 120;
  localparam int unsigned HoldOffLen  = 600;
  // A value yields up to 20 digit beats, so any quiet period well beyond the
  // long hold-off means the block is stuck.
  localparam int unsigned QuietLimit  = 3000;
  // Cycles left to run once nothing is outstanding, to catch stray beats.
  localparam int unsigned DrainCycles = 120;

  logic        clk_i;
  logic        rst_ni;
  int unsigned values_sent;
  bit          stimulus_done;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  bda_value_if value_if ();
  bda_digit_if digit_if ();

  binary_to_decimal_ascii dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_if),
    .digit_o (digit_if)
  );

  bda_digit_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_mon    (value_if),
    .digit_mon    (digit_if),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Reset is held only at the very start and never asserted again.
  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Returns ten to the power k; k runs from 0 to 19 inside 64 bits.
  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Offers one value and returns at the edge that accepts it. When idling
  // is allowed, a random burst of empty cycles may follow the beat; without
  // one, valid simply stays high for the next value.
  task automatic offer_value(input logic [63:0] v, input bit may_idle);
    value_if.valid <= 1'b1;
    value_if.value <= v;
    @(posedge clk_i);
    while (!value_if.ready) @(posedge clk_i);
    values_sent++;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      value_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Value source: a directed set first, then shaped random values.
  initial begin : value_source
    logic [63:0] directed [$];
    logic [63:0] v;
    int          kind;
    int          bits;
    bit          idle_phase;

    value_if.valid <= 1'b0;
    value_if.value <= '0;
    values_sent   = 0;
    stimulus_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Zero gives a lone '0'; single and double digits; the digit-count
    // boundaries around powers of ten; the 32-bit edges, which must behave
    // as zero-extended values; alternating bit patterns; and the full
    // 64-bit maximum together with ten to the 19th, both 20 digits long.
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                 64'd1234567890, 64'd9876543210,
                 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
                 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'd12345678901234567890,
                 pow10(18) - 64'd1, pow10(18), pow10(19) - 64'd1, pow10(19),
                 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (directed[i]) offer_value(directed[i], 1'b1);

    // Random values. Half have a random bit length so that every digit
    // count turns up often; the rest hit power-of-ten borders, tiny values,
    // the top of the range, plain 32-bit values and full 64-bit noise.
    idle_phase = 1'b1;
    while (values_sent < TotalValues) begin
      if (values_sent % 40 == 0) idle_phase = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      case (kind)
        0, 1, 2, 3, 4: begin
          bits = $urandom_range(1, 64);
          if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
        end
        5: ;
        6: begin
          v = pow10($urandom_range(0, 19)) - 64'($urandom_range(0, 1));
        end
        7: v = 64'($urandom_range(0, 99));
        8: v = ~64'($urandom_range(0, 1000));
        default: v = {32'd0, v[31:0]};
      endcase
      offer_value(v, idle_phase && values_sent < TotalValues - TailValues);
    end
    value_if.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Digit sink: random stalls in bursts, one long hold-off that backs the
  // block up while the source keeps offering, and no stalls near the end.
  initial begin : digit_sink
    bit held_off;
    held_off = 1'b0;
    digit_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_off && values_sent >= HoldOffAt) begin
        held_off = 1'b1;
        digit_if.ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
      end else if (!stimulus_done && values_sent < TotalValues - TailValues &&
                   $urandom_range(0, 2) == 0) begin
        digit_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      digit_if.ready <= 1'b1;
      // Ready runs are mostly short, now and then long enough to let
      // several whole digit runs through without a single stall.
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (value_if.valid && value_if.ready) ||
        (digit_if.valid && digit_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of run: once every value is in and no digit is outstanding, let
  // the block sit a while longer so a stray extra beat would be caught.
  initial begin : verdict
    quiet_cycles = 0;
    wait (stimulus_done);
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bda_pkg.sv
rtl/bda_value_if.sv
rtl/bda_digit_if.sv
rtl/bda_dabble_step.sv
rtl/binary_to_decimal_ascii.sv
tb/bda_digit_checker.sv
tb/binary_to_decimal_ascii_tb.sv
